/* design/upc_pkg.sv */
// Shared types, character constants and helper functions for the URL percent codec.
package upc_pkg;

   typedef enum logic {
      MODE_ENCODE = 1'b0,
      MODE_DECODE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_PCT   = 2'd1,
      PHASE_DIGIT = 2'd2
   } phase_type;

   // Most output words one input word can produce
   localparam int unsigned SLOTS = 3;
   localparam int unsigned CNT_W = $clog2(SLOTS + 1);
   localparam int unsigned IDX_W = $clog2(SLOTS);

   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UPA   = 8'h41;
   localparam logic [7:0] CH_UPZ   = 8'h5A;
   localparam logic [7:0] CH_LOA   = 8'h61;
   localparam logic [7:0] CH_LOZ   = 8'h7A;
   localparam logic [7:0] CASE_OFS = 8'h20;
   // 'a' - 10, so a letter maps to its hex value
   localparam logic [7:0] ALPHA_OFS = 8'd87;

   localparam logic [7:0] HEX_DIGITS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
   };

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       bare;
   } slot_type;

   typedef struct packed {
      logic [CNT_W-1:0]        count;
      slot_type [SLOTS-1:0]    slot;
   } bundle_type;

   function automatic logic passes_plain(input logic [7:0] c);
      logic ok;
      ok = (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UPA && c <= CH_UPZ) ||
           (c >= CH_LOA && c <= CH_LOZ) || c == CH_DASH || c == CH_UNDER ||
           c == CH_DOT || c == CH_TILDE || c == CH_SLASH;
      return ok;
   endfunction

   // Unchecked hex value, wrapping modulo 256 for non-hex characters
   function automatic logic [7:0] hexval(input logic [7:0] c);
      logic [7:0] l;
      l = (c >= CH_UPA && c <= CH_UPZ) ? c + CASE_OFS : c;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         l = c - CH_ZERO;
      end else begin
         l = l - ALPHA_OFS;
      end
      return l;
   endfunction

endpackage

/* design/upc_stream_if.sv */
// Valid/ready channel interfaces for the codec's request and response streams.
interface upc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_end;
   logic       carries_no_byte;

   modport source (output valid, output out_byte, output out_end,
                   output carries_no_byte, input ready);
   modport sink   (input valid, input out_byte, input out_end,
                   input carries_no_byte, output ready);
endinterface

/* design/upc_xlate.sv */
// Input register, escape-tracking state and per-word translation into a result bundle.
module upc_xlate (
   input  logic                 clock,
   input  logic                 reset,
   input  upc_pkg::mode_type    mode,
   input  logic                 cfg_clear,
   upc_req_if.sink              req,
   output upc_pkg::bundle_type  bundle,
   output logic                 bundle_valid,
   input  logic                 bundle_ready
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_data_ff;
   logic                in_last_ff;
   upc_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]          held_ff, held_in;
   logic                advance;
   logic [7:0]          hv_hi, hv_lo, decoded;

   // Move the held word on when it yields nothing or the emitter takes it
   assign advance      = in_valid_ff && (bundle.count == '0 || bundle_ready);
   assign req.ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req.valid && req.ready) || (in_valid_ff && !advance);
   assign bundle_valid = in_valid_ff && bundle.count != '0;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req.valid && req.ready) begin
         in_data_ff <= req.in_byte;
         in_last_ff <= req.in_last;
      end
   end

   // Escape state, dropped on any mode write
   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         phase_ff <= upc_pkg::PHASE_IDLE;
         held_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   // Next escape state
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      if (advance) begin
         if (mode == upc_pkg::MODE_ENCODE) begin
            phase_in = upc_pkg::PHASE_IDLE;
         end else begin
            unique case (phase_ff)
               upc_pkg::PHASE_PCT: begin
                  if (in_last_ff) begin
                     phase_in = upc_pkg::PHASE_IDLE;
                  end else begin
                     held_in  = in_data_ff;
                     phase_in = upc_pkg::PHASE_DIGIT;
                  end
               end
               upc_pkg::PHASE_DIGIT: begin
                  phase_in = upc_pkg::PHASE_IDLE;
               end
               default: begin
                  phase_in = (in_data_ff == upc_pkg::CH_PCT && !in_last_ff) ?
                             upc_pkg::PHASE_PCT : upc_pkg::PHASE_IDLE;
               end
            endcase
         end
      end
   end

   // Combine the two escape digits
   always_comb begin
      hv_hi   = upc_pkg::hexval(held_ff);
      hv_lo   = upc_pkg::hexval(in_data_ff);
      decoded = {hv_hi[3:0], 4'b0000} | hv_lo;
   end

   // Result words for the held input word
   always_comb begin
      bundle = '0;
      if (mode == upc_pkg::MODE_ENCODE) begin
         if (upc_pkg::passes_plain(in_data_ff)) begin
            bundle.count        = upc_pkg::CNT_W'(1);
            bundle.slot[0].data = in_data_ff;
            bundle.slot[0].last = in_last_ff;
         end else begin
            bundle.count        = upc_pkg::CNT_W'(3);
            bundle.slot[0].data = upc_pkg::CH_PCT;
            bundle.slot[1].data = upc_pkg::HEX_DIGITS[in_data_ff[7:4]];
            bundle.slot[2].data = upc_pkg::HEX_DIGITS[in_data_ff[3:0]];
            bundle.slot[2].last = in_last_ff;
         end
      end else begin
         unique case (phase_ff)
            upc_pkg::PHASE_PCT: begin
               if (in_last_ff) begin
                  bundle.count        = upc_pkg::CNT_W'(1);
                  bundle.slot[0].last = 1'b1;
                  if (in_data_ff == upc_pkg::CH_PCT) begin
                     bundle.slot[0].bare = 1'b1;
                  end else begin
                     bundle.slot[0].data = in_data_ff;
                  end
               end
            end
            upc_pkg::PHASE_DIGIT: begin
               bundle.count        = upc_pkg::CNT_W'(1);
               bundle.slot[0].data = decoded;
               bundle.slot[0].last = in_last_ff;
            end
            default: begin
               if (in_data_ff != upc_pkg::CH_PCT) begin
                  bundle.count        = upc_pkg::CNT_W'(1);
                  bundle.slot[0].data = in_data_ff;
                  bundle.slot[0].last = in_last_ff;
               end else if (in_last_ff) begin
                  bundle.count        = upc_pkg::CNT_W'(1);
                  bundle.slot[0].last = 1'b1;
                  bundle.slot[0].bare = 1'b1;
               end
            end
         endcase
      end
   end

endmodule

/* design/upc_emit.sv */
// Output register that holds one result bundle and hands its words out one per cycle unless stalled.
module upc_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  upc_pkg::bundle_type  bundle,
   input  logic                 bundle_valid,
   output logic                 bundle_ready,
   upc_rsp_if.source            rsp
);

   logic                                  valid_ff, valid_in;
   upc_pkg::slot_type [upc_pkg::SLOTS-1:0] slot_ff;
   logic [upc_pkg::IDX_W-1:0]             last_idx_ff;
   logic [upc_pkg::IDX_W-1:0]             ptr_ff, ptr_in;
   logic                                  drain, final_word, load;

   assign drain        = rsp.valid && rsp.ready;
   assign final_word   = ptr_ff == last_idx_ff;
   assign bundle_ready = !valid_ff || (drain && final_word);
   assign load         = bundle_valid && bundle_ready;
   assign valid_in     = load || (valid_ff && !(drain && final_word));

   // Advance through the bundle, restart on a new one
   always_comb begin
      ptr_in = ptr_ff;
      if (load) begin
         ptr_in = '0;
      end else if (drain) begin
         ptr_in = ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ptr_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         ptr_ff   <= ptr_in;
      end
      if (load) begin
         slot_ff     <= bundle.slot;
         last_idx_ff <= upc_pkg::IDX_W'(bundle.count - 1'b1);
      end
   end

   // Present the current word
   assign rsp.valid           = valid_ff;
   assign rsp.out_byte        = slot_ff[ptr_ff].data;
   assign rsp.out_end         = slot_ff[ptr_ff].last;
   assign rsp.carries_no_byte = slot_ff[ptr_ff].bare;

endmodule

/* design/url_percent_codec.sv */
// URL percent codec: with csr mode 0 each input word is passed through when it is an
// alphanumeric or one of - _ . ~ / and otherwise expanded to '%' and two uppercase hex
// digits; with mode 1 "%XY" sequences collapse to one word and everything else is copied,
// but an escape cut short by a string's end yields the word after '%', or a bare end
// marker if that is '%' or missing. A word is taken every cycle while each yields at most
// one result and the output is not stalled; an escaped encode-mode word holds the output
// register while its three result words go out, one per cycle when not stalled. Write
// the mode only while the codec is idle; a write also discards any half-received escape.
module url_percent_codec (
   input  logic       clock,
   input  logic       reset,
   upc_req_if.sink    req_if,
   upc_rsp_if.source  rsp_if,
   input  logic       csr_we,
   input  logic       csr_wdata
);

   upc_pkg::mode_type   mode_ff;
   upc_pkg::bundle_type bundle;
   logic                bundle_valid;
   logic                bundle_ready;

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= upc_pkg::MODE_ENCODE;
      end else if (csr_we) begin
         mode_ff <= upc_pkg::mode_type'(csr_wdata);
      end
   end

   upc_xlate u_xlate (
      .clock        (clock),
      .reset        (reset),
      .mode         (mode_ff),
      .cfg_clear    (csr_we),
      .req          (req_if),
      .bundle       (bundle),
      .bundle_valid (bundle_valid),
      .bundle_ready (bundle_ready)
   );

   upc_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .bundle       (bundle),
      .bundle_valid (bundle_valid),
      .bundle_ready (bundle_ready),
      .rsp          (rsp_if)
   );

endmodule

/* design/upc_checker.sv */
// Port-level assertions for the URL percent codec and their bind to the top level.
module upc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_end,
   input logic       rsp_carries_no_byte
);

   // Hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_out_end) && $stable(rsp_carries_no_byte))
      else $error("response word changed while stalled");

   // Drop any response after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // Accept input right after reset
   a_req_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("request not ready right after reset");

   // A bare end marker ends the string and carries a zero byte
   a_bare_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_carries_no_byte |-> rsp_out_end && rsp_out_byte == 8'd0)
      else $error("bare marker without end flag or with data");

endmodule

bind url_percent_codec upc_checker u_upc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_if.ready),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_out_byte        (rsp_if.out_byte),
   .rsp_out_end         (rsp_if.out_end),
   .rsp_carries_no_byte (rsp_if.carries_no_byte)
);

/* tb/sv/url_percent_codec_tb.sv */
// Self-checking testbench for url_percent_codec: directed table, then random strings in both modes.
module url_percent_codec_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam upc_pkg::mode_type ENC = upc_pkg::MODE_ENCODE;
   localparam upc_pkg::mode_type DEC = upc_pkg::MODE_DECODE;
   localparam logic [7:0]        PCT = upc_pkg::CH_PCT;

   // One row of stimulus: a mode write or one input word, with optional typed-in results
   typedef struct packed {
      logic                     cfg;
      upc_pkg::mode_type        mode;
      logic [7:0]               b;
      logic                     fin;
      logic                     typed;
      logic [1:0]               n;
      upc_pkg::slot_type [0:2]  exp;
   } stim_row_type;

   localparam upc_pkg::slot_type NONE     = '0;
   localparam upc_pkg::slot_type BARE_END = '{8'h00, 1'b1, 1'b1};
   localparam int       SETTLE   = 8;
   localparam int       LIMIT    = 400000;
   localparam int       PHASE_WORDS = 70;

   localparam stim_row_type DIRECTED [27] = '{
      // encode, straight out of reset
      '{1'b0, ENC, 8'h41, 1'b0, 1'b1, 2'd1, '{'{8'h41, 1'b0, 1'b0}, NONE, NONE}},
      '{1'b0, ENC, 8'h01, 1'b0, 1'b1, 2'd3,
        '{'{8'h25, 1'b0, 1'b0}, '{8'h30, 1'b0, 1'b0}, '{8'h31, 1'b0, 1'b0}}},
      '{1'b0, ENC, 8'hFF, 1'b1, 1'b1, 2'd3,
        '{'{8'h25, 1'b0, 1'b0}, '{8'h46, 1'b0, 1'b0}, '{8'h46, 1'b1, 1'b0}}},
      '{1'b0, ENC, 8'h20, 1'b0, 1'b1, 2'd3,
        '{'{8'h25, 1'b0, 1'b0}, '{8'h32, 1'b0, 1'b0}, '{8'h30, 1'b0, 1'b0}}},
      '{1'b0, ENC, 8'h7E, 1'b1, 1'b1, 2'd1, '{'{8'h7E, 1'b1, 1'b0}, NONE, NONE}},
      '{1'b0, ENC, PCT, 1'b0, 1'b1, 2'd3,
        '{'{8'h25, 1'b0, 1'b0}, '{8'h32, 1'b0, 1'b0}, '{8'h35, 1'b0, 1'b0}}},
      '{1'b0, ENC, 8'h39, 1'b1, 1'b0, 2'd0, '0},
      '{1'b1, DEC, 8'h00, 1'b0, 1'b0, 2'd0, '0},
      // decode: well-formed escapes, upper and lower case
      '{1'b0, DEC, PCT, 1'b0, 1'b1, 2'd0, '0},
      '{1'b0, DEC, 8'h34, 1'b0, 1'b1, 2'd0, '0},
      '{1'b0, DEC, 8'h31, 1'b0, 1'b1, 2'd1, '{'{8'h41, 1'b0, 1'b0}, NONE, NONE}},
      '{1'b0, DEC, PCT, 1'b0, 1'b1, 2'd0, '0},
      '{1'b0, DEC, 8'h66, 1'b0, 1'b1, 2'd0, '0},
      '{1'b0, DEC, 8'h46, 1'b1, 1'b1, 2'd1, '{'{8'hFF, 1'b1, 1'b0}, NONE, NONE}},
      // non-hex digits wrap without a check
      '{1'b0, DEC, PCT, 1'b0, 1'b0, 2'd0, '0},
      '{1'b0, DEC, 8'h47, 1'b0, 1'b0, 2'd0, '0},
      '{1'b0, DEC, 8'h7A, 1'b0, 1'b0, 2'd0, '0},
      // short escapes at the end of a string
      '{1'b0, DEC, PCT, 1'b1, 1'b1, 2'd1, '{BARE_END, NONE, NONE}},
      '{1'b0, DEC, PCT, 1'b0, 1'b1, 2'd0, '0},
      '{1'b0, DEC, 8'h51, 1'b1, 1'b1, 2'd1, '{'{8'h51, 1'b1, 1'b0}, NONE, NONE}},
      '{1'b0, DEC, PCT, 1'b0, 1'b1, 2'd0, '0},
      '{1'b0, DEC, PCT, 1'b1, 1'b1, 2'd1, '{BARE_END, NONE, NONE}},
      '{1'b0, DEC, 8'hFF, 1'b1, 1'b1, 2'd1, '{'{8'hFF, 1'b1, 1'b0}, NONE, NONE}},
      // a mode write drops a half-received escape
      '{1'b0, DEC, PCT, 1'b0, 1'b1, 2'd0, '0},
      '{1'b1, DEC, 8'h00, 1'b0, 1'b0, 2'd0, '0},
      '{1'b0, DEC, 8'h34, 1'b0, 1'b1, 2'd1, '{'{8'h34, 1'b0, 1'b0}, NONE, NONE}},
      '{1'b0, DEC, 8'h31, 1'b1, 1'b1, 2'd1, '{'{8'h31, 1'b1, 1'b0}, NONE, NONE}}
   };

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   upc_req_if req_if();
   upc_rsp_if rsp_if();

   url_percent_codec dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Codec state as the checker sees it
   upc_pkg::mode_type  pred_mode  = upc_pkg::MODE_ENCODE;
   upc_pkg::phase_type pred_phase = upc_pkg::PHASE_IDLE;
   logic [7:0]         pred_held  = '0;

   stim_row_type      rows_in_flight[$];
   upc_pkg::slot_type words_due[$];
   int        fail_count = 0;
   int        cycle_count = 0;
   int        send_gap = 0;
   int        recv_stall = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic is_unreserved(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
             c == "-" || c == "_" || c == "." || c == "~" || c == "/";
   endfunction

   // Hex digit value, wrapping modulo 256 for anything that is not a digit
   function automatic logic [7:0] nibble_of(input logic [7:0] c);
      logic [7:0] l;
      if (c >= "0" && c <= "9") begin
         return c - "0";
      end
      l = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      return l - "a" + 8'd10;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      return (v < 4'd10) ? "0" + v : "A" + v - 8'd10;
   endfunction

   // Advance the codec state by one word and return the words it yields
   function automatic int codec_step(input logic [7:0] b, input logic fin,
                                     output upc_pkg::slot_type [0:2] res);
      logic [7:0] v;
      res = '0;
      if (pred_mode == upc_pkg::MODE_ENCODE) begin
         pred_phase = upc_pkg::PHASE_IDLE;
         if (is_unreserved(b)) begin
            res[0] = '{b, fin, 1'b0};
            return 1;
         end
         res[0] = '{PCT, 1'b0, 1'b0};
         res[1] = '{hex_char(b[7:4]), 1'b0, 1'b0};
         res[2] = '{hex_char(b[3:0]), fin, 1'b0};
         return 3;
      end
      case (pred_phase)
         upc_pkg::PHASE_PCT: begin
            if (!fin) begin
               pred_held = b;
               pred_phase = upc_pkg::PHASE_DIGIT;
               return 0;
            end
            pred_phase = upc_pkg::PHASE_IDLE;
            if (b == PCT) begin
               res[0] = BARE_END;
            end else begin
               res[0] = '{b, 1'b1, 1'b0};
            end
            return 1;
         end
         upc_pkg::PHASE_DIGIT: begin
            v = (nibble_of(pred_held) << 4) | nibble_of(b);
            res[0] = '{v, fin, 1'b0};
            pred_phase = upc_pkg::PHASE_IDLE;
            return 1;
         end
         default: begin
            pred_phase = upc_pkg::PHASE_IDLE;
            if (b != PCT) begin
               res[0] = '{b, fin, 1'b0};
               return 1;
            end
            if (fin) begin
               res[0] = BARE_END;
               return 1;
            end
            pred_phase = upc_pkg::PHASE_PCT;
            return 0;
         end
      endcase
   endfunction

   // Track mode writes and accepted words, check every result word
   always @(posedge clock) begin
      upc_pkg::slot_type [0:2] res;
      stim_row_type            row;
      upc_pkg::slot_type       want;
      int                      n;
      if (!reset) begin
         if (csr_we) begin
            pred_mode = upc_pkg::mode_type'(csr_wdata);
            pred_phase = upc_pkg::PHASE_IDLE;
            pred_held = '0;
         end
         if (req_if.valid && req_if.ready) begin
            row = rows_in_flight.pop_front();
            n = codec_step(req_if.in_byte, req_if.in_last, res);
            if (row.typed) begin
               n = row.n;
               res = row.exp;
            end
            for (int k = 0; k < n; k++) begin
               words_due.push_back(res[k]);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (words_due.size() == 0) begin
               $error("unexpected word: out_byte %h out_end %b carries_no_byte %b",
                      rsp_if.out_byte, rsp_if.out_end, rsp_if.carries_no_byte);
               fail_count++;
            end else begin
               want = words_due.pop_front();
               if (rsp_if.out_byte !== want.data) begin
                  $error("out_byte: expected %h, got %h", want.data, rsp_if.out_byte);
                  fail_count++;
               end
               if (rsp_if.out_end !== want.last) begin
                  $error("out_end: expected %b, got %b", want.last, rsp_if.out_end);
                  fail_count++;
               end
               if (rsp_if.carries_no_byte !== want.bare) begin
                  $error("carries_no_byte: expected %b, got %b", want.bare,
                         rsp_if.carries_no_byte);
                  fail_count++;
               end
            end
         end
      end
   end

   // Stall the result side at random
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   // Abort a run that hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("url_percent_codec_tb: errors");
         $finish;
      end
   end

   // Offer one word, idling first at random, and hold it until taken
   task automatic send_word(input stim_row_type row);
      while ($urandom_range(99) < send_gap) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      rows_in_flight.push_back(row);
      req_if.valid <= 1'b1;
      req_if.in_byte <= row.b;
      req_if.in_last <= row.fin;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drop valid and wait until the codec has nothing left to give
   task automatic settle();
      req_if.valid <= 1'b0;
      while (words_due.size() != 0 || rows_in_flight.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_mode(input upc_pkg::mode_type m);
      settle();
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Build one random string, mostly well-formed for the mode, and send it
   task automatic send_string(input upc_pkg::mode_type m, output int count);
      string      plain = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-_.~/";
      string      hx = "0123456789ABCDEFabcdef";
      logic [7:0] s[$];
      stim_row_type row;
      int         r;
      repeat ($urandom_range(1, 6)) begin
         r = $urandom_range(99);
         if (m == upc_pkg::MODE_ENCODE) begin
            s.push_back(r < 50 ? plain[$urandom_range(plain.len() - 1)]
                               : 8'($urandom_range(1, 255)));
         end else if (r < 45) begin
            s.push_back(PCT);
            s.push_back(hx[$urandom_range(hx.len() - 1)]);
            s.push_back(hx[$urandom_range(hx.len() - 1)]);
         end else if (r < 55) begin
            s.push_back(PCT);
            s.push_back(8'($urandom_range(1, 255)));
            s.push_back(8'($urandom_range(1, 255)));
         end else if (r < 90) begin
            s.push_back(8'($urandom_range(1, 255)));
         end else begin
            s.push_back(PCT);
         end
      end
      foreach (s[i]) begin
         row = '0;
         row.mode = m;
         row.b = s[i];
         row.fin = (i == s.size() - 1);
         send_word(row);
      end
      count = s.size();
   endtask

   initial begin
      int                sent;
      int                got;
      upc_pkg::mode_type m;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      req_if.valid = 1'b0;
      req_if.in_byte = '0;
      req_if.in_last = 1'b0;
      send_gap = 30;
      recv_stall = 78;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].cfg) begin
            write_mode(DIRECTED[i].mode);
         end else begin
            send_word(DIRECTED[i]);
         end
      end

      // Random strings: both modes under each idling pattern
      for (int ph = 0; ph < 6; ph++) begin
         send_gap = (ph < 2) ? 30 : (ph < 4) ? 78 : 0;
         recv_stall = (ph < 2) ? 78 : (ph < 4) ? 30 : 0;
         m = (ph % 2 == 0) ? ENC : DEC;
         write_mode(m);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            send_string(m, got);
            sent += got;
         end
      end

      settle();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && words_due.size() == 0) begin
         $display("url_percent_codec_tb: clean");
      end else begin
         $display("url_percent_codec_tb: errors");
      end
      $finish;
   end

endmodule

/* files.f */
design/upc_pkg.sv
design/upc_stream_if.sv
design/upc_xlate.sv
design/upc_emit.sv
design/url_percent_codec.sv
design/upc_checker.sv
tb/sv/url_percent_codec_tb.sv
